// ===== hdl/ubdr_pkg.sv =====
// Package for the unorm bit-depth rescaler: register map, widths, config struct.
// No dependencies; used by ubdr_pipe, the top level and the checker.
package ubdr_pkg;

    // depth register width and reset depth
    localparam int REG_W  = 5;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int OUT_W  = 16;

    typedef logic [REG_W-1:0] t_depth_reg;

    localparam t_depth_reg DEPTH_RESET = 5'd8;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_SOURCE = 1'b0;
    localparam logic REG_IDX_TARGET = 1'b1;

    // raw depth registers as seen by the datapath
    typedef struct packed {
        t_depth_reg source_bits;
        t_depth_reg target_bits;
    } t_cfg;

endpackage

// ===== hdl/ubdr_pipe.sv =====
// Rescale datapath: clamp depths, mask, top-align, bit-replicate, shift down.
// Depends on ubdr_pkg (t_cfg, t_depth_reg, OUT_W).
module ubdr_pipe #(
    parameter int MAX_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ubdr_pkg::t_cfg                i_cfg,
    input  logic                          i_vld,
    input  logic [ubdr_pkg::OUT_W-1:0]    i_sample,
    output logic                          o_vld,
    output logic [ubdr_pkg::OUT_W-1:0]    o_value
);

    localparam int W  = MAX_BITS;
    localparam int DW = $clog2(MAX_BITS + 1);
    localparam int K  = $clog2(MAX_BITS);
    localparam int VW = (W > ubdr_pkg::OUT_W) ? W : ubdr_pkg::OUT_W;
    localparam int SW = DW + K;
    localparam logic [DW-1:0] W_D = DW'(MAX_BITS);
    localparam ubdr_pkg::t_depth_reg MAX_DEPTH = ubdr_pkg::t_depth_reg'(MAX_BITS);

    // pipeline registers: stage 0 holds the top-aligned sample, stage k
    // holds 2^k copies of it
    logic [W-1:0]  r_x   [0:K];
    logic [DW-1:0] r_p   [0:K];
    logic [DW-1:0] r_n   [0:K-1];
    logic          r_vld [0:K];
    logic [ubdr_pkg::OUT_W-1:0] r_out;
    logic                       r_ovld;

    logic [DW-1:0] n_src_depth;
    logic [DW-1:0] n_tgt_depth;
    logic [VW-1:0] n_mask;
    logic [VW-1:0] n_masked;
    logic [W-1:0]  n_x0;
    logic [W-1:0]  n_res;
    logic [VW-1:0] n_res_ext;

    // clamp both depths into 1..MAX_BITS
    always_comb begin
        if (i_cfg.source_bits == '0) begin
            n_src_depth = DW'(1);
        end else if (i_cfg.source_bits > MAX_DEPTH) begin
            n_src_depth = W_D;
        end else begin
            n_src_depth = DW'(i_cfg.source_bits);
        end
        if (i_cfg.target_bits == '0) begin
            n_tgt_depth = DW'(1);
        end else if (i_cfg.target_bits > MAX_DEPTH) begin
            n_tgt_depth = W_D;
        end else begin
            n_tgt_depth = DW'(i_cfg.target_bits);
        end
    end

    // mask to source width and put the sample at the top of the word
    assign n_mask   = ~({VW{1'b1}} << n_src_depth);
    assign n_masked = VW'(i_sample) & n_mask;
    assign n_x0     = n_masked[W-1:0] << (W_D - n_src_depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_x[0] <= n_x0;
        r_n[0] <= n_src_depth;
        r_p[0] <= n_tgt_depth;
    end

    // doubling stages: OR in a copy shifted by n * 2^(k-1)
    for (genvar k = 1; k <= K; k++) begin : g_rep
        logic [SW-1:0] n_shamt;
        assign n_shamt = SW'(r_n[k-1]) << (k - 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_x[k] <= r_x[k-1] | (r_x[k-1] >> n_shamt);
            r_p[k] <= r_p[k-1];
        end

        if (k < K) begin : g_n
            always_ff @(posedge i_clk) begin
                r_n[k] <= r_n[k-1];
            end
        end
    end

    // keep the top target_bits bits of the replicated pattern
    assign n_res     = r_x[K] >> (W_D - r_p[K]);
    assign n_res_ext = VW'(n_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[K];
        end
        r_out <= n_res_ext[ubdr_pkg::OUT_W-1:0];
    end

    assign o_vld   = r_ovld;
    assign o_value = r_out;

endmodule

// ===== hdl/unorm_bit_depth_rescale_top.sv =====
// An accepted sample passes the input register, the doubling stages and the output register,
// then shows on o_converted_value with o_done high.
// Throughput: one sample per cycle; busy is low whenever reset is released.
// Every widening step is one replication stage, so depth grows with clog2(MAX_BITS).
// Reset (synchronous, active low) flushes the pipeline and sets both depths to 8.
// Top level: APB depth registers and the rescale pipeline; depends on ubdr_pkg, ubdr_pipe.
module unorm_bit_depth_rescale_top #(
    parameter int MAX_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [15:0]                    i_sample_value,
    // result channel
    output logic                           o_done,
    output logic [15:0]                    o_converted_value,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ubdr_pkg::ADDR_W-1:0]    paddr,
    input  logic [ubdr_pkg::DATA_W-1:0]    pwdata,
    output logic [ubdr_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    ubdr_pkg::t_depth_reg r_source_bits;
    ubdr_pkg::t_depth_reg r_target_bits;
    ubdr_pkg::t_cfg       cfg;
    logic                 n_wr;
    logic                 n_accept;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite && pready;

    // depth registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_bits <= ubdr_pkg::DEPTH_RESET;
            r_target_bits <= ubdr_pkg::DEPTH_RESET;
        end else if (n_wr) begin
            case (paddr[2])
                ubdr_pkg::REG_IDX_SOURCE: r_source_bits <= pwdata[ubdr_pkg::REG_W-1:0];
                ubdr_pkg::REG_IDX_TARGET: r_target_bits <= pwdata[ubdr_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[2])
            ubdr_pkg::REG_IDX_SOURCE: prdata = ubdr_pkg::DATA_W'(r_source_bits);
            ubdr_pkg::REG_IDX_TARGET: prdata = ubdr_pkg::DATA_W'(r_target_bits);
            default:                  prdata = '0;
        endcase
    end

    // commands are refused only while reset is held
    assign busy     = !i_rst_n;
    assign n_accept = start && !busy;

    assign cfg.source_bits = r_source_bits;
    assign cfg.target_bits = r_target_bits;

    ubdr_pipe #(
        .MAX_BITS (MAX_BITS)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_vld    (n_accept),
        .i_sample (i_sample_value),
        .o_vld    (o_done),
        .o_value  (o_converted_value)
    );

endmodule

// ===== hdl/ubdr_checker.sv =====
// Port-level checker for the rescaler: beat timing, reset flush, register readback.
// Depends on ubdr_pkg; bound to unorm_bit_depth_rescale_top below.
module ubdr_checker #(
    parameter int MAX_BITS = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [ubdr_pkg::ADDR_W-1:0] paddr,
    input logic [ubdr_pkg::DATA_W-1:0] pwdata,
    input logic [ubdr_pkg::DATA_W-1:0] prdata
);

    // sampled distance from an accepted beat to its result beat
    localparam int LAT = $clog2(MAX_BITS) + 2;

    // every accepted beat yields a result beat a fixed time later
    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted beat produced no result");

    // no result beat without a matching accepted beat
    a_done_source: assert property (@(posedge i_clk)
        o_done |-> $past(start && !busy && i_rst_n, LAT))
        else $error("result beat without accepted beat");

    // reset flushes the result strobe
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result beat right after reset");

    // a written source depth reads back on the next cycle
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[2] == ubdr_pkg::REG_IDX_SOURCE))
        ##1 (psel && !pwrite && (paddr[2] == ubdr_pkg::REG_IDX_SOURCE))
        |-> (prdata == ubdr_pkg::DATA_W'($past(pwdata[ubdr_pkg::REG_W-1:0], 1))))
        else $error("source depth readback mismatch");

endmodule

bind unorm_bit_depth_rescale_top ubdr_checker #(
    .MAX_BITS (MAX_BITS)
) u_ubdr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);

// ===== verif/ubdr_rescale_checker.sv =====
`timescale 1ns / 100ps
// Checker for unorm_bit_depth_rescale_top: follows APB depth writes, predicts every sample beat
// and compares converted values in order. Depends on ubdr_pkg.
module ubdr_rescale_checker #(
    parameter int MAX_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [15:0]                  i_sample_value,
    input  logic                         i_done,
    input  logic [15:0]                  i_converted_value,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [ubdr_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [ubdr_pkg::DATA_W-1:0]  i_pwdata,
    input  logic                         i_pready,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the depth registers, raw as written
    ubdr_pkg::t_cfg depth_regs;
    logic [15:0]    converted_queue[$];
    int             fail_count = 0;
    int             pending = 0;
    int             checked = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    // zero means one bit, anything past MAX_BITS saturates
    function automatic int unsigned effective_depth(input ubdr_pkg::t_depth_reg raw);
        if (raw == '0)
            return 1;
        if (raw > MAX_BITS)
            return MAX_BITS;
        return 32'(raw);
    endfunction

    function automatic logic [15:0] rescaled_sample(input logic [15:0] raw,
                                                    input ubdr_pkg::t_cfg cfg);
        int unsigned     n;
        int unsigned     p;
        longint unsigned full_scale;
        longint unsigned v;
        n = effective_depth(cfg.source_bits);
        p = effective_depth(cfg.target_bits);
        full_scale = (64'd1 << n) - 64'd1;
        v = {48'd0, raw} & full_scale;
        if (n > p)
            return 16'(v >> (n - p));
        if (n == p)
            return 16'(v);
        if (v == 0)
            return '0;
        if (v == full_scale)
            return 16'((64'd1 << p) - 64'd1);
        // product held at 64 bits, so it never wraps
        return 16'((v << p) / full_scale);
    endfunction

    task automatic note_failure(input string what, input logic [15:0] want_value,
                                input logic [15:0] got_value);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected 0x%04h, got 0x%04h", $realtime, what, want_value,
                     got_value);
    endtask

    always @(posedge i_clk) begin
        logic [15:0] want_value;
        if (!i_rst_n) begin
            depth_regs <= '{source_bits: ubdr_pkg::DEPTH_RESET,
                            target_bits: ubdr_pkg::DEPTH_RESET};
            converted_queue.delete();
        end else begin
            // result beat: compare against the oldest prediction
            if (i_done) begin
                if (converted_queue.size() == 0) begin
                    note_failure("result with nothing outstanding", 16'h0000,
                                 i_converted_value);
                end else begin
                    want_value = converted_queue.pop_front();
                    checked++;
                    if (want_value !== i_converted_value)
                        note_failure("converted_value mismatch", want_value,
                                     i_converted_value);
                end
            end
            // depth register write, low five bits kept
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == ubdr_pkg::REG_IDX_SOURCE)
                    depth_regs.source_bits <= i_pwdata[ubdr_pkg::REG_W-1:0];
                else
                    depth_regs.target_bits <= i_pwdata[ubdr_pkg::REG_W-1:0];
            end
            // accepted sample beat, appended at the tail
            if (i_start && !i_busy)
                converted_queue = {converted_queue,
                                   rescaled_sample(i_sample_value, depth_regs)};
        end
        pending = converted_queue.size();
    end

endmodule

// ===== verif/tb_unorm_bit_depth_rescale_top.sv =====
`timescale 1ns / 100ps
// Testbench top for unorm_bit_depth_rescale_top: clock, reset, APB depth writes and sample beats.
// Depends on ubdr_pkg, the block and ubdr_rescale_checker.
module tb_unorm_bit_depth_rescale_top;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;   // pipeline holds six beats
    localparam int PHASES       = 10;
    localparam int PHASE_BEATS  = 45;

    localparam logic [ubdr_pkg::ADDR_W-1:0] ADDR_SOURCE = {ubdr_pkg::REG_IDX_SOURCE, 2'b00};
    localparam logic [ubdr_pkg::ADDR_W-1:0] ADDR_TARGET = {ubdr_pkg::REG_IDX_TARGET, 2'b00};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [15:0]                   i_sample_value;
    logic                          o_done;
    logic [15:0]                   o_converted_value;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ubdr_pkg::ADDR_W-1:0]   paddr;
    logic [ubdr_pkg::DATA_W-1:0]   pwdata;
    logic [ubdr_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    int          fail_count;
    int          pending_count;
    int          checked_count;
    int          beats_sent = 0;
    int          depth_writes = 0;
    int unsigned cycle_count = 0;
    int unsigned src_depth = 8;   // effective source depth, steers corner values
    logic        accept_q = 1'b0;

    unorm_bit_depth_rescale_top #(.MAX_BITS(16)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_sample_value    (i_sample_value),
        .o_done            (o_done),
        .o_converted_value (o_converted_value),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    ubdr_rescale_checker #(.MAX_BITS(16)) u_rescale_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_sample_value    (i_sample_value),
        .i_done            (o_done),
        .i_converted_value (o_converted_value),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_fail_count      (fail_count),
        .o_pending         (pending_count),
        .o_checked         (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // beat-accept flag for the driver, plus the watchdog
    always @(posedge i_clk) begin
        accept_q <= start && !busy;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // all driver tasks start and end at a falling edge
    task automatic send_sample(input logic [15:0] value, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_sample_value <= value;
        do @(negedge i_clk); while (!accept_q);
        beats_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_depth(input logic [ubdr_pkg::ADDR_W-1:0] addr,
                               input logic [ubdr_pkg::REG_W-1:0] depth);
        logic [ubdr_pkg::DATA_W-1:0] word;
        word = $urandom();          // upper bits are junk the block must drop
        word[ubdr_pkg::REG_W-1:0] = depth;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // psel stays low before the next transfer
        @(negedge i_clk);
        depth_writes++;
    endtask

    // registers only change with the pipeline empty
    task automatic set_depths(input logic [ubdr_pkg::REG_W-1:0] src,
                              input logic [ubdr_pkg::REG_W-1:0] dst);
        drain_results();
        write_depth(ADDR_SOURCE, src);
        write_depth(ADDR_TARGET, dst);
        src_depth = (src == 0) ? 1 : (src > 16) ? 16 : src;
    endtask

    // mix of plain noise and values that land on zero or full scale after masking
    function automatic logic [15:0] pick_sample(input int unsigned n);
        logic [15:0] low_mask;
        logic [15:0] noise;
        low_mask = 16'((32'd1 << n) - 1);
        noise = 16'($urandom());
        case ($urandom_range(0, 7))
            0: return noise | low_mask;
            1: return noise & ~low_mask;
            2: return (noise & ~low_mask) | 16'd1;
            3: return (noise | low_mask) ^ 16'd1;
            default: return noise;
        endcase
    endfunction

    initial begin
        int idle_pct;
        logic [ubdr_pkg::REG_W-1:0] src;
        logic [ubdr_pkg::REG_W-1:0] dst;
        start          = 1'b0;
        i_sample_value = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_rst_n        = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset depths, equal width passes through with the mask
        send_sample(16'h0000, 0);
        send_sample(16'hFFFF, 0);
        send_sample(16'hAB5A, 0);
        send_sample(16'h0080, 0);
        // widening 4 -> 12: zero, full scale, interior, masked-away bits
        set_depths(5'd4, 5'd12);
        send_sample(16'h0000, 0);
        send_sample(16'h000F, 0);
        send_sample(16'h0007, 0);
        send_sample(16'hFFF0, 0);
        send_sample(16'h0001, 0);
        // narrowing 16 -> 1
        set_depths(5'd16, 5'd1);
        send_sample(16'hFFFF, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h7FFF, 0);
        // zero depth acts as one bit, out-of-range depth saturates
        set_depths(5'd0, 5'd31);
        send_sample(16'h0001, 0);
        send_sample(16'hFFFE, 0);
        set_depths(5'd31, 5'd0);
        send_sample(16'h8000, 0);
        send_sample(16'h7FFF, 0);
        // widest widening steps
        set_depths(5'd1, 5'd16);
        send_sample(16'h0001, 0);
        send_sample(16'h0000, 0);
        set_depths(5'd15, 5'd16);
        send_sample(16'h7FFE, 0);
        send_sample(16'h4000, 0);
        send_sample(16'h0001, 0);

        // random phases: fixed extremes first, then random depths
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin src = 5'd16; dst = 5'd16; end
                1: begin src = 5'd1;  dst = 5'd1;  end
                2: begin src = 5'd16; dst = 5'd1;  end
                3: begin src = 5'd1;  dst = 5'd16; end
                default: begin
                    src = ubdr_pkg::REG_W'($urandom_range(0, 31));
                    dst = ubdr_pkg::REG_W'($urandom_range(0, 31));
                end
            endcase
            case (phase % 4)
                1: idle_pct = 71;
                3: idle_pct = 26;
                default: idle_pct = 0;
            endcase
            set_depths(src, dst);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                // hold off mid-phase until the pipeline has emptied
                if (phase == 5 && k == PHASE_BEATS / 2)
                    drain_results();
                send_sample(pick_sample(src_depth), idle_pct);
            end
        end

        drain_results();
        $display("%0d sample beats sent, %0d conversions checked, %0d depth writes", beats_sent,
                 checked_count, depth_writes);
        $display("depths covered: equal, widening, narrowing, zero and saturated registers");
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
